// ----- hdl/urd_pkg.sv -----
// ----------------------------------------------------------------------------
// urd_pkg
// Shared types, register map and codes of the UART register device.
// ----------------------------------------------------------------------------
`default_nettype none

package urd_pkg;

   // sizes
   localparam int REGISTER_WORDS = 32;
   localparam int RX_FIFO_DEPTH  = 16;

   localparam int RW_IDX_W = $clog2(REGISTER_WORDS);
   localparam int PTR_W    = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
   localparam int CNT_W    = $clog2(RX_FIFO_DEPTH + 1);

   // word indexes of the register map
   localparam int IDX_DR  = 0;
   localparam int IDX_RSR = 1;
   localparam int IDX_FR  = 6;
   localparam int IDX_CR  = 12;
   localparam int IDX_ICR = 17;

   // register bits
   localparam logic [31:0] FR_RXE  = 32'h0000_0010;
   localparam logic [31:0] FR_RXF  = 32'h0000_0040;
   localparam logic [31:0] CR_EN   = 32'h0000_0001;
   localparam logic [31:0] CR_TXIE = 32'h0000_0100;
   localparam logic [31:0] CR_RXIE = 32'h0000_0200;
   localparam logic [31:0] ICR_RX  = 32'h0000_0010;
   localparam logic [31:0] ICR_TX  = 32'h0000_0020;

   localparam logic [31:0] FR_RESET  = 32'h0000_0090;
   localparam logic [31:0] READ_ONES = 32'hffff_ffff;

   localparam logic [7:0] WINDOW_RESET = 8'd128;

   // request op codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_RX    = 2'd2;

   // interrupt line commands
   localparam logic [1:0] IRQ_NONE = 2'd0;
   localparam logic [1:0] IRQ_SET  = 2'd1;
   localparam logic [1:0] IRQ_CLR  = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  offset;
      logic [31:0] wdata;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic [1:0]  irq_cmd;
      logic        wake;
      logic        rx_dropped;
   } rsp_type;

   // receive fifo control and status
   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] data;
   } fifo_ctl_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [7:0]       head;
   } fifo_stat_type;

endpackage

`default_nettype wire

// ----- hdl/urd_csr.sv -----
// ----------------------------------------------------------------------------
// urd_csr
// Configuration port holding the decode window size.
// ----------------------------------------------------------------------------
`default_nettype none

module urd_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output logic      [7:0]  window_size
);

   logic [7:0] window_ff;
   logic [7:0] window_in;
   logic       wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel & penable & pwrite & ~paddr[2];

   always_comb begin
      window_in = window_ff;
      if (wr_hit) begin
         window_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= urd_pkg::WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   assign prdata      = paddr[2] ? 32'd0 : {24'd0, window_ff};
   assign window_size = window_ff;

endmodule

`default_nettype wire

// ----- hdl/urd_rx_fifo.sv -----
// ----------------------------------------------------------------------------
// urd_rx_fifo
// Receive character fifo with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module urd_rx_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire urd_pkg::fifo_ctl_type  ctl,
   output urd_pkg::fifo_stat_type      stat
);

   logic [7:0]                 fifo_ff [urd_pkg::RX_FIFO_DEPTH];
   logic [urd_pkg::PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [urd_pkg::PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [urd_pkg::CNT_W-1:0]  count_ff, count_in;

   localparam logic [urd_pkg::PTR_W-1:0] LAST_SLOT =
      urd_pkg::PTR_W'(urd_pkg::RX_FIFO_DEPTH - 1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // character storage, no reset
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         fifo_ff[wr_ptr_ff] <= ctl.data;
      end
   end

   assign stat.count = count_ff;
   assign stat.head  = fifo_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- hdl/urd_regfile.sv -----
// ----------------------------------------------------------------------------
// urd_regfile
// Register words and the per-request decode and update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module urd_regfile (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire urd_pkg::req_type       req,
   input  wire logic [7:0]             window_size,
   input  wire urd_pkg::fifo_stat_type fifo_stat,
   output urd_pkg::fifo_ctl_type       fifo_ctl,
   output urd_pkg::rsp_type            rsp
);

   localparam logic [urd_pkg::RW_IDX_W-1:0] I_DR  = urd_pkg::RW_IDX_W'(urd_pkg::IDX_DR);
   localparam logic [urd_pkg::RW_IDX_W-1:0] I_RSR = urd_pkg::RW_IDX_W'(urd_pkg::IDX_RSR);
   localparam logic [urd_pkg::RW_IDX_W-1:0] I_FR  = urd_pkg::RW_IDX_W'(urd_pkg::IDX_FR);
   localparam logic [urd_pkg::RW_IDX_W-1:0] I_CR  = urd_pkg::RW_IDX_W'(urd_pkg::IDX_CR);
   localparam logic [urd_pkg::RW_IDX_W-1:0] I_ICR = urd_pkg::RW_IDX_W'(urd_pkg::IDX_ICR);
   localparam logic [urd_pkg::CNT_W-1:0]    FULL_CNT =
      urd_pkg::CNT_W'(urd_pkg::RX_FIFO_DEPTH);

   logic [31:0] regs_ff [urd_pkg::REGISTER_WORDS];
   logic [31:0] regs_in [urd_pkg::REGISTER_WORDS];

   logic [5:0]                  word_idx;
   logic [urd_pkg::RW_IDX_W-1:0] ri;
   logic                        in_window;
   logic [31:0]                 cr;
   logic                        fifo_full;
   logic                        has_data;
   logic                        more_after_pop;
   logic                        full_after_push;
   urd_pkg::rsp_type            rsp_c;
   urd_pkg::fifo_ctl_type       ctl_c;

   assign word_idx  = req.offset[7:2];
   assign ri        = word_idx[urd_pkg::RW_IDX_W-1:0];
   assign in_window = (req.offset < window_size) &&
                      (7'(word_idx) < 7'(urd_pkg::REGISTER_WORDS));
   assign cr        = regs_ff[I_CR];
   assign fifo_full = (fifo_stat.count >= FULL_CNT);
   assign has_data  = (fifo_stat.count != '0);
   // a pop leaves bytes behind when more than one was there
   assign more_after_pop  = (fifo_stat.count > urd_pkg::CNT_W'(1));
   // a push fills the fifo when one slot was left
   assign full_after_push = fifo_full || (fifo_stat.count == FULL_CNT - 1'b1);

   always_comb begin
      regs_in = regs_ff;
      rsp_c   = '0;
      ctl_c   = '0;
      ctl_c.data = req.rx_byte;

      if (req.op == urd_pkg::OP_RX) begin
         if (fifo_full) begin
            rsp_c.rx_dropped = 1'b1;
         end else begin
            ctl_c.push = 1'b1;
         end
         regs_in[I_FR] = regs_ff[I_FR] & ~urd_pkg::FR_RXE;
         if (full_after_push) begin
            regs_in[I_FR] = regs_in[I_FR] | urd_pkg::FR_RXF;
         end
         if (((cr & urd_pkg::CR_RXIE) != '0) && ((cr & urd_pkg::CR_EN) != '0)) begin
            regs_in[I_ICR] = regs_ff[I_ICR] | urd_pkg::ICR_RX;
            rsp_c.irq_cmd  = urd_pkg::IRQ_SET;
            rsp_c.wake     = 1'b1;
         end
      end else if ((req.op == urd_pkg::OP_READ || req.op == urd_pkg::OP_WRITE)
                   && in_window) begin
         if (ri == I_DR) begin
            if ((cr & urd_pkg::CR_EN) == '0) begin
               if (req.op == urd_pkg::OP_READ) begin
                  rsp_c.rdata = urd_pkg::READ_ONES;
               end
            end else if (req.op == urd_pkg::OP_READ) begin
               if (has_data) begin
                  rsp_c.rdata  = {24'd0, fifo_stat.head};
                  ctl_c.pop    = 1'b1;
                  regs_in[I_RSR] = '0;
               end else begin
                  rsp_c.rdata = urd_pkg::READ_ONES;
               end
               if (more_after_pop) begin
                  regs_in[I_FR] = (regs_ff[I_FR] & ~urd_pkg::FR_RXE) | urd_pkg::FR_RXF;
                  if ((cr & urd_pkg::CR_RXIE) != '0) begin
                     regs_in[I_ICR] = regs_ff[I_ICR] | urd_pkg::ICR_RX;
                     rsp_c.irq_cmd  = urd_pkg::IRQ_SET;
                  end
               end else begin
                  regs_in[I_FR] = (regs_ff[I_FR] | urd_pkg::FR_RXE) & ~urd_pkg::FR_RXF;
                  if ((cr & urd_pkg::CR_RXIE) != '0) begin
                     regs_in[I_ICR] = regs_ff[I_ICR] & ~urd_pkg::ICR_RX;
                     rsp_c.irq_cmd  = urd_pkg::IRQ_CLR;
                  end
               end
            end else begin
               rsp_c.tx_valid = 1'b1;
               rsp_c.tx_byte  = req.wdata[7:0];
            end
         end else if (req.op == urd_pkg::OP_READ) begin
            rsp_c.rdata = regs_ff[ri];
         end else if (ri == I_RSR) begin
            regs_in[I_RSR] = '0;
         end else if (ri == I_CR) begin
            if ((req.wdata & urd_pkg::CR_EN) != '0) begin
               if ((req.wdata & urd_pkg::CR_TXIE) != '0) begin
                  regs_in[I_ICR] = regs_in[I_ICR] | urd_pkg::ICR_TX;
                  rsp_c.irq_cmd  = urd_pkg::IRQ_SET;
               end else begin
                  regs_in[I_ICR] = regs_in[I_ICR] & ~urd_pkg::ICR_TX;
                  rsp_c.irq_cmd  = urd_pkg::IRQ_CLR;
               end
               if ((req.wdata & urd_pkg::CR_RXIE) != '0) begin
                  if (has_data) begin
                     regs_in[I_ICR] = regs_in[I_ICR] | urd_pkg::ICR_RX;
                     rsp_c.irq_cmd  = urd_pkg::IRQ_SET;
                  end
               end else begin
                  regs_in[I_ICR] = regs_in[I_ICR] & ~urd_pkg::ICR_RX;
                  rsp_c.irq_cmd  = urd_pkg::IRQ_CLR;
               end
            end else begin
               regs_in[I_ICR] = regs_in[I_ICR] & ~(urd_pkg::ICR_TX | urd_pkg::ICR_RX);
               rsp_c.irq_cmd  = urd_pkg::IRQ_CLR;
            end
            regs_in[I_CR] = req.wdata;
         end else begin
            regs_in[ri] = req.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // all words clear except the flag word
         for (int i = 0; i < urd_pkg::REGISTER_WORDS; i++) begin
            regs_ff[i] <= (i == urd_pkg::IDX_FR) ? urd_pkg::FR_RESET : '0;
         end
      end else if (fire) begin
         regs_ff <= regs_in;
      end
   end

   assign fifo_ctl.push = ctl_c.push & fire;
   assign fifo_ctl.pop  = ctl_c.pop & fire;
   assign fifo_ctl.data = ctl_c.data;
   assign rsp           = rsp_c;

endmodule

`default_nettype wire

// ----- hdl/uart_register_device.sv -----
// ----------------------------------------------------------------------------
// uart_register_device
// Single-channel UART register block: bus reads and writes plus arrivals of
// received characters, with a receive fifo and interrupt line commands.
// ----------------------------------------------------------------------------
// path: a request accepted into the request register passes the decode and
//   update logic into the response register, and waits while that is held
// throughput: one request per cycle while responses are taken, set by the single
//   decode-and-update pass between the request register and the response register
// reset: synchronous, active high; registers clear (flag word to 0x90), fifo
//   empties, window size returns to 128; usable in the cycle after reset
`default_nettype none

module uart_register_device (
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire urd_pkg::req_type req_data,
   // response channel
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output urd_pkg::rsp_type      rsp_data,
   // configuration port
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready
);

   // request stage
   logic             in_vld_ff, in_vld_in;
   urd_pkg::req_type in_ff, in_in;
   // response stage
   logic             out_vld_ff, out_vld_in;
   urd_pkg::rsp_type out_ff, out_in;

   logic                   advance;
   logic [7:0]             window_size;
   urd_pkg::rsp_type       rsp_next;
   urd_pkg::fifo_ctl_type  fifo_ctl;
   urd_pkg::fifo_stat_type fifo_stat;

   // the held request moves on whenever the response slot is free or draining
   assign advance   = in_vld_ff & (~out_vld_ff | rsp_ready);
   assign req_ready = ~in_vld_ff | advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      in_in     = in_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
         in_in     = req_data;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (advance) begin
         out_vld_in = 1'b1;
         out_in     = rsp_next;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // window size register
   urd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .window_size (window_size)
   );

   // decode, register words and interrupt handling
   urd_regfile u_regfile (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .req         (in_ff),
      .window_size (window_size),
      .fifo_stat   (fifo_stat),
      .fifo_ctl    (fifo_ctl),
      .rsp         (rsp_next)
   );

   // receive character fifo
   urd_rx_fifo u_rx_fifo (
      .clock (clock),
      .reset (reset),
      .ctl   (fifo_ctl),
      .stat  (fifo_stat)
   );

endmodule

`default_nettype wire
